FILE: rtl/tbfa_pkg.sv
// Shared types, constants and coefficient functions for the two-band row analysis filter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package tbfa_pkg;

  // Filter geometry. The coefficient table below is fixed at eight taps.
  localparam int TAPS   = 8;
  localparam int HALF   = TAPS / 2;
  localparam int COEF_W = 16;
  localparam int OUT_W  = 18;
  localparam int FRAC_W = 15;
  localparam int POS_W  = 13;

  localparam logic [POS_W-1:0] LEN_MIN   = POS_W'(8);
  localparam logic [POS_W-1:0] LEN_MAX   = POS_W'(4096);
  localparam logic [POS_W-1:0] LEN_RESET = POS_W'(512);

  // Depth of the result queue and the width of its pointers and fill count.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // Daubechies-8 taps in Q1.15, rounded to nearest.
  localparam logic signed [COEF_W-1:0] DB8_Q15 [TAPS] = '{
    16'sd7549, 16'sd23424, 16'sd20673, -16'sd917,
    -16'sd6129, 16'sd1011, 16'sd1078, -16'sd347
  };

  typedef enum logic [0:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_KEEP_PHASE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] low_band;
    logic signed [OUT_W-1:0] high_band;
    logic                    is_border;
    logic                    row_done;
  } result_t;

  // Up to two results enter the queue per accepted sample.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    item0;
    result_t    item1;
  } push_t;

  // Lowpass weight for the sample of a given age.
  function automatic logic signed [COEF_W-1:0] coef_lo(input int age);
    return DB8_Q15[age];
  endfunction

  // Highpass weight for the sample of a given age: mirrored taps, odd ages negated.
  function automatic logic signed [COEF_W-1:0] coef_hi(input int age);
    logic signed [COEF_W-1:0] c;
    c = DB8_Q15[TAPS-1-age];
    if ((age % 2) == 1) begin
      return -c;
    end
    return c;
  endfunction

endpackage

FILE: rtl/tbfa_cell.sv
// One cell of the transposed filter chain: holds the lowpass and highpass partial sums.
// Depends on tbfa_pkg for the coefficient functions.
module tbfa_cell #(
  parameter int IDX      = 1,
  parameter int SAMPLE_W = 16,
  parameter int ACC_W    = 35
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [ACC_W-1:0]    acc_lo_i,
  input  logic signed [ACC_W-1:0]    acc_hi_i,
  output logic signed [ACC_W-1:0]    acc_lo_o,
  output logic signed [ACC_W-1:0]    acc_hi_o
);

  localparam int PROD_W = SAMPLE_W + tbfa_pkg::COEF_W;
  localparam logic signed [tbfa_pkg::COEF_W-1:0] CLO = tbfa_pkg::coef_lo(IDX);
  localparam logic signed [tbfa_pkg::COEF_W-1:0] CHI = tbfa_pkg::coef_hi(IDX);

  logic signed [PROD_W-1:0] prod_lo, prod_hi;
  logic signed [ACC_W-1:0]  acc_lo_d, acc_lo_q, acc_hi_d, acc_hi_q;

  assign prod_lo  = sample_i * CLO;
  assign prod_hi  = sample_i * CHI;
  assign acc_lo_d = ACC_W'(prod_lo) + acc_lo_i;
  assign acc_hi_d = ACC_W'(prod_hi) + acc_hi_i;

  // Partial sums move one cell toward the output on every accepted sample.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_lo_q <= acc_lo_d;
      acc_hi_q <= acc_hi_d;
    end
  end

  assign acc_lo_o = acc_lo_q;
  assign acc_hi_o = acc_hi_q;

endmodule

FILE: rtl/tbfa_out_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on tbfa_pkg for result_t, push_t and the queue depth.
module tbfa_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbfa_pkg::push_t     push_i,
  input  logic                pop_i,
  output tbfa_pkg::result_t   head_o,
  output logic                valid_o,
  output logic                room_o
);

  localparam int PW = tbfa_pkg::OQ_PTR_W;
  localparam int CW = tbfa_pkg::OQ_CNT_W;

  tbfa_pkg::result_t mem_q [tbfa_pkg::OQ_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  // Room for two results, so a row end never has to wait.
  assign room_o  = (cnt_q <= CW'(tbfa_pkg::OQ_DEPTH - 2));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + PW'(push_i.cnt);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push_i.item1;
    end
  end

endmodule

FILE: rtl/two_band_fir_analysis_row.sv
// Top level of the two-band row analysis filter (Daubechies-8 lowpass/highpass pair).
// Depends on tbfa_pkg, tbfa_cell and tbfa_out_fifo.
//
// Usage: row samples enter on the input channel (sample_i, in_valid_i/in_ready_o),
// one transfer per clock at full rate while in_ready_o is high. Results leave on the output channel
// (low_band_o, high_band_o, is_border_o, row_done_o, out_valid_o/out_ready_i).
// Only positions whose parity equals keep_phase give a result. The result for
// position j is formed in the cycle in which the sample of position j+3 is
// transferred and is registered into the result queue. The last sample of
// a row flushes the final kept positions as two border results, the second of
// them marked with row_done_o. The filter itself is a chain of seven cells
// that carry transposed partial sums, so any input pattern sustains one sample
// per cycle while in_ready_o is high. A four-entry result queue separates the
// two sides; in_ready_o drops only while more than two results wait, so a stalled
// receiver holds the input back after at most a few transfers and nothing is lost.
// The configuration port writes row_length (index 0) and keep_phase (index 1);
// write it only while no row is in flight. Reset sets row_length to 512,
// keep_phase to 0, the row position to zero and empties the result queue.
module two_band_fir_analysis_row #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tbfa_pkg::OUT_W-1:0]    low_band_o,
  output logic signed [tbfa_pkg::OUT_W-1:0]    high_band_o,
  output logic                                 is_border_o,
  output logic                                 row_done_o,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_idx_i,
  input  logic [tbfa_pkg::POS_W-1:0]           cfg_data_i
);

  localparam int TAPS   = tbfa_pkg::TAPS;
  localparam int HALF   = tbfa_pkg::HALF;
  localparam int OUT_W  = tbfa_pkg::OUT_W;
  localparam int POS_W  = tbfa_pkg::POS_W;
  localparam int PROD_W = SAMPLE_BITS + tbfa_pkg::COEF_W;
  // Eight products need three extra bits of headroom.
  localparam int ACC_W  = PROD_W + $clog2(TAPS);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (tbfa_pkg::FRAC_W - 1);
  localparam logic [POS_W-1:0] FIRST_OUT = POS_W'(HALF - 1);
  localparam logic [POS_W-1:0] FIRST_FILT = POS_W'(2 * HALF - 1);

  // Configuration registers.
  logic [POS_W-1:0] row_length_q;
  logic             keep_phase_q;

  // Row position and the short sample history used for border pass-through.
  logic [POS_W-1:0]             pos_q, pos_d;
  logic signed [SAMPLE_BITS-1:0] hist_q [HALF-1];

  logic             in_fire;
  logic [POS_W-1:0] len_eff;
  logic             last;
  logic             p_match;

  // Transposed filter chain: index g holds the partial sum of cell g.
  logic signed [ACC_W-1:0]  acc_lo [1:TAPS];
  logic signed [ACC_W-1:0]  acc_hi [1:TAPS];
  logic signed [PROD_W-1:0] prod0_lo, prod0_hi;
  logic signed [ACC_W-1:0]  sum_lo, sum_hi;
  logic signed [ACC_W-1:0]  rnd_lo, rnd_hi;
  logic signed [OUT_W-1:0]  filt_lo, filt_hi;

  logic signed [OUT_W-1:0]  age0_s, age1_s, age2_s, age3_s;

  tbfa_pkg::push_t   push;
  tbfa_pkg::result_t head;

  // Clamp to the signed output range by looking at the bits above it.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-OUT_W:0] upper;
    upper = v[ACC_W-1:OUT_W-1];
    if ((&upper) || !(|upper)) begin
      return v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= tbfa_pkg::LEN_RESET;
      keep_phase_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbfa_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data_i;
        tbfa_pkg::REG_KEEP_PHASE: keep_phase_q <= cfg_data_i[0];
      endcase
    end
  end

  // Out-of-range row lengths act as the nearest legal one.
  always_comb begin
    priority if (row_length_q < tbfa_pkg::LEN_MIN) begin
      len_eff = tbfa_pkg::LEN_MIN;
    end else if (row_length_q > tbfa_pkg::LEN_MAX) begin
      len_eff = tbfa_pkg::LEN_MAX;
    end else begin
      len_eff = row_length_q;
    end
  end

  assign last    = (pos_q >= len_eff - POS_W'(1));
  assign p_match = (pos_q[0] == keep_phase_q);
  assign pos_d   = last ? '0 : pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hist_q[0] <= sample_i;
      for (int k = 1; k < HALF - 1; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // Chain of cells; the cell farthest from the output starts from zero.
  assign acc_lo[TAPS] = '0;
  assign acc_hi[TAPS] = '0;

  for (genvar g = 1; g < TAPS; g++) begin : g_cell
    tbfa_cell #(
      .IDX      (g),
      .SAMPLE_W (SAMPLE_BITS),
      .ACC_W    (ACC_W)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (in_fire),
      .sample_i (sample_i),
      .acc_lo_i (acc_lo[g+1]),
      .acc_hi_i (acc_hi[g+1]),
      .acc_lo_o (acc_lo[g]),
      .acc_hi_o (acc_hi[g])
    );
  end

  // The newest sample closes both sums; then round half up and saturate.
  assign prod0_lo = sample_i * tbfa_pkg::coef_lo(0);
  assign prod0_hi = sample_i * tbfa_pkg::coef_hi(0);
  assign sum_lo   = ACC_W'(prod0_lo) + acc_lo[1];
  assign sum_hi   = ACC_W'(prod0_hi) + acc_hi[1];
  assign rnd_lo   = (sum_lo + ROUND_HALF) >>> tbfa_pkg::FRAC_W;
  assign rnd_hi   = (sum_hi + ROUND_HALF) >>> tbfa_pkg::FRAC_W;
  assign filt_lo  = sat_out(rnd_lo);
  assign filt_hi  = sat_out(rnd_hi);

  // Border values are the samples themselves, by age relative to the current one.
  assign age0_s = sat_out(ACC_W'(sample_i));
  assign age1_s = sat_out(ACC_W'(hist_q[0]));
  assign age2_s = sat_out(ACC_W'(hist_q[1]));
  assign age3_s = sat_out(ACC_W'(hist_q[2]));

  always_comb begin
    push = '0;
    if (in_fire) begin
      if (last) begin
        // Row end: the two kept positions among the final four pass through.
        push.cnt             = 2'd2;
        push.item0.low_band  = p_match ? age2_s : age3_s;
        push.item0.high_band = p_match ? age2_s : age3_s;
        push.item0.is_border = 1'b1;
        push.item1.low_band  = p_match ? age0_s : age1_s;
        push.item1.high_band = p_match ? age0_s : age1_s;
        push.item1.is_border = 1'b1;
        push.item1.row_done  = 1'b1;
      end else if (pos_q >= FIRST_OUT && !p_match) begin
        // Position three back is kept when the current position's parity differs from keep_phase.
        push.cnt = 2'd1;
        if (pos_q < FIRST_FILT) begin
          push.item0.low_band  = age3_s;
          push.item0.high_band = age3_s;
          push.item0.is_border = 1'b1;
        end else begin
          push.item0.low_band  = filt_lo;
          push.item0.high_band = filt_hi;
        end
      end
    end
  end

  tbfa_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .room_o  (in_ready_o)
  );

  assign low_band_o  = head.low_band;
  assign high_band_o = head.high_band;
  assign is_border_o = head.is_border;
  assign row_done_o  = head.row_done;

`ifndef SYNTHESIS
  // A row end always returns the position to the start of the next row.
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last) |=> (pos_q == '0))
    else $error("row position did not wrap after the last sample");

  // The position never passes the longest legal row.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < tbfa_pkg::LEN_MAX)
    else $error("row position out of range");

  // Back-pressure on the input only comes from results waiting on the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // The final result of a row is always a passed-through sample.
  a_done_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && row_done_o) |-> is_border_o)
    else $error("row end marked on a filtered result");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the two-band row analysis filter (lowpass/highpass pair).
// It predicts every result, drives both handshake channels with random idling, checks each
// transfer, and depends only on tbfa_pkg and two_band_fir_analysis_row.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS   = tbfa_pkg::TAPS;
  localparam int HALF   = tbfa_pkg::HALF;
  localparam int OUT_W  = tbfa_pkg::OUT_W;
  localparam int POS_W  = tbfa_pkg::POS_W;
  localparam int FRAC_W = tbfa_pkg::FRAC_W;
  localparam logic [POS_W-1:0] LEN_MIN   = tbfa_pkg::LEN_MIN;
  localparam logic [POS_W-1:0] LEN_MAX   = tbfa_pkg::LEN_MAX;
  localparam logic [POS_W-1:0] LEN_RESET = tbfa_pkg::LEN_RESET;

  localparam int SAMPLE_W      = 16;
  localparam int RANDOM_ITEMS  = 1200;
  // The slowest legal run (every gap and every stall at its longest) stays well
  // within this.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // A result is queued by the sample that completes it; this pause also
  // covers samples that produce nothing while the block may still be busy.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int SQUEEZE_AT    = 150;
  localparam int SQUEEZE_LEN   = 400;

  // Q1.15 Daubechies-8 weights in natural order.
  localparam longint TAP_Q15 [TAPS] = '{7549, 23424, 20673, -917, -6129, 1011, 1078, -347};

  typedef enum logic {
    STEP_SAMPLE,
    STEP_WRITE
  } step_kind_e;

  // One line of the directed script. A sample line may carry a typed border value:
  // then that pass-through result is expected instead of the predicted one.
  typedef struct {
    step_kind_e          kind;
    tbfa_pkg::cfg_reg_e  sel;
    int                  value;
    bit                  typed;
    int                  border_value;
  } directed_step_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          out_ready_i = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample_i    = '0;
  logic [0:0]                    cfg_idx_i   = '0;
  logic [POS_W-1:0]              cfg_data_i  = '0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic signed [OUT_W-1:0]       low_band_o;
  logic signed [OUT_W-1:0]       high_band_o;
  logic                          is_border_o;
  logic                          row_done_o;

  two_band_fir_analysis_row #(
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .low_band_o (low_band_o),
    .high_band_o(high_band_o),
    .is_border_o(is_border_o),
    .row_done_o (row_done_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // The predictor's own copy of the block state, at its reset values.
  logic signed [SAMPLE_W-1:0] past [TAPS-1] = '{default: '0};
  logic [POS_W-1:0]           row_pos       = '0;
  logic [POS_W-1:0]           row_len       = LEN_RESET;
  logic                       keep_odd      = 1'b0;

  // Band results that the accepted samples have caused and that have not yet left.
  tbfa_pkg::result_t bands_due [$];
  int      mismatches   = 0;
  int      results_seen = 0;

  // The directed script runs right after reset, so the first rows see row_length 512
  // and the even phase. It covers the sample extremes, the passed-through borders at
  // the row start, a filtered position, a row cut short by shrinking row_length while
  // the position is already past the new end, and a row_length below the minimum.
  directed_step_t script [20] = '{
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,  32767, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH, -32768, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,      0, 1'b0,      0},
    // Position 0 leaves on the step of position 3 as a border result.
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,     -1, 1'b1,  32767},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,      1, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,  12345, 1'b1,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,  32767, 1'b0,      0},
    // Position 4 is the first one that gets filtered.
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,  32767, 1'b0,      0},
    // The row is now at position 8, past the new last position: the next sample
    // closes the row and flushes border results only.
    '{STEP_WRITE,  tbfa_pkg::REG_ROW_LENGTH,      8, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,    100, 1'b0,      0},
    '{STEP_WRITE,  tbfa_pkg::REG_KEEP_PHASE,      1, 1'b0,      0},
    // A row_length of zero behaves as the minimum length of eight.
    '{STEP_WRITE,  tbfa_pkg::REG_ROW_LENGTH,      0, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,      7, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH, -32768, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,  21845, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH, -21846, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,      0, 1'b1, -32768},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH, -32768, 1'b0,      0},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH,  32767, 1'b1, -21846},
    '{STEP_SAMPLE, tbfa_pkg::REG_ROW_LENGTH, -32768, 1'b0,      0}
  };

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint sample_at(input longint cur, input int age);
    if (age == 0) begin
      return cur;
    end
    return past[age-1];
  endfunction

  function automatic logic signed [OUT_W-1:0] clip(input longint v);
    longint top;
    top = (longint'(1) <<< (OUT_W - 1)) - 1;
    if (v > top) begin
      return top[OUT_W-1:0];
    end
    if (v < -top - 1) begin
      return OUT_W'(-top - 1);
    end
    return v[OUT_W-1:0];
  endfunction

  // Works out the results of one accepted sample and advances the predicted state.
  // The result for position j needs the sample of j+3, so on an ordinary step only
  // position p-3 can leave; the last step of a row also flushes p-2 .. p.
  task automatic analyze_sample(input logic signed [SAMPLE_W-1:0] cur, input bit keep);
    longint  len;
    longint  p;
    longint  j;
    longint  acc_lo;
    longint  acc_hi;
    longint  s;
    int      d;
    int      count;
    bit      last;
    bit      border;
    tbfa_pkg::result_t r;
    tbfa_pkg::result_t found [$];

    len = row_len;
    if (len < LEN_MIN) begin
      len = LEN_MIN;
    end
    if (len > LEN_MAX) begin
      len = LEN_MAX;
    end
    p     = row_pos;
    last  = (p >= len - 1);
    count = last ? HALF : 1;

    for (int k = 0; k < count; k++) begin
      j = p - (HALF - 1) + k;
      d = (HALF - 1) - k;
      if (j < 0 || (j % 2) != keep_odd) begin
        continue;
      end
      // Only the ordinary step of a position away from both row ends is filtered.
      border = (j < HALF) || (j >= len - HALF) || (d != HALF - 1);
      if (border) begin
        r.low_band  = clip(sample_at(cur, d));
        r.high_band = r.low_band;
      end else begin
        acc_lo = 0;
        acc_hi = 0;
        for (int t = 0; t < TAPS; t++) begin
          s = sample_at(cur, TAPS - 1 - t);
          acc_lo += s * TAP_Q15[TAPS-1-t];
          if (((TAPS - 1 - t) % 2) == 1) begin
            acc_hi -= s * TAP_Q15[t];
          end else begin
            acc_hi += s * TAP_Q15[t];
          end
        end
        // Round half up, then floor by the arithmetic shift.
        r.low_band  = clip((acc_lo + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
        r.high_band = clip((acc_hi + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
      end
      r.is_border = border;
      r.row_done  = 1'b0;
      found.push_back(r);
    end
    if (last && found.size() > 0) begin
      found[found.size()-1].row_done = 1'b1;
    end
    if (keep) begin
      foreach (found[i]) begin
        bands_due.push_back(found[i]);
      end
    end

    // The window is never cleared between rows.
    for (int i = TAPS - 2; i > 0; i--) begin
      past[i] = past[i-1];
    end
    past[0] = cur;
    row_pos = last ? '0 : row_pos + 1'b1;
  endtask

  // Idle lengths: mostly none, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return SAMPLE_W'($urandom());
    end
    if (r < 70) begin
      return 16'sh7fff;
    end
    if (r < 85) begin
      return 16'sh8000;
    end
    return SAMPLE_W'(int'($urandom_range(0, 31)) - 16);
  endfunction

  // Offers one sample after an optional gap and holds it until the transfer. When
  // the gap is zero, valid simply stays high from the previous transfer.
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input int gap,
                              input bit typed, input int border_value);
    tbfa_pkg::result_t r;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    analyze_sample(s, !typed);
    if (typed) begin
      r.low_band  = OUT_W'(border_value);
      r.high_band = OUT_W'(border_value);
      r.is_border = 1'b1;
      r.row_done  = 1'b0;
      bands_due.push_back(r);
    end
  endtask

  // Registers change only once every expected result has left and the block has
  // had time to finish work on samples that produce nothing.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (bands_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The write enable drops for a cycle between writes so that it is never lowered
  // and raised in the same time step.
  task automatic write_reg(input tbfa_pkg::cfg_reg_e sel, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= value[POS_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == tbfa_pkg::REG_ROW_LENGTH) begin
      row_len = value[POS_W-1:0];
    end else begin
      keep_odd = value[0];
    end
    @(posedge clk_i);
  endtask

  task automatic check_band_result();
    tbfa_pkg::result_t got;
    tbfa_pkg::result_t want;
    got.low_band  = low_band_o;
    got.high_band = high_band_o;
    got.is_border = is_border_o;
    got.row_done  = row_done_o;
    results_seen++;
    if (bands_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("result %0d: none expected, got low %0d high %0d border %0b done %0b",
                 results_seen, got.low_band, got.high_band, got.is_border, got.row_done);
      end
    end else begin
      want = bands_due.pop_front();
      if (got.low_band !== want.low_band || got.high_band !== want.high_band ||
          got.is_border !== want.is_border || got.row_done !== want.row_done) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d: expected low %0d high %0d border %0b done %0b",
                   results_seen, want.low_band, want.high_band, want.is_border,
                   want.row_done);
          $display("result %0d:      got low %0d high %0d border %0b done %0b",
                   results_seen, got.low_band, got.high_band, got.is_border, got.row_done);
        end
      end
    end
  endtask

  // Receiver: checks every output transfer and stalls at random. Some stretches run
  // with no stall at all. Once, while the sender is offering, it holds ready low
  // for a long stretch so that the result queue fills and the block has to drop
  // its input ready.
  int rx_hold      = 0;
  int rx_cycle     = 0;
  bit rx_steady    = 1'b0;
  bit squeeze_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_band_result();
    end
    rx_cycle++;
    if (rx_cycle % 256 == 0) begin
      rx_steady = ($urandom_range(0, 3) == 0);
    end
    if (!squeeze_done && results_seen >= SQUEEZE_AT && in_valid_i) begin
      squeeze_done = 1'b1;
      rx_hold      = SQUEEZE_LEN;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_steady) begin
        rx_hold = pick_gap();
      end
    end
  end

  // Watchdog: a run that does not end on its own within the limit fails.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    int  sent;
    int  len_val;
    int  eff_len;
    int  n;
    int  r;
    bit  big_done;
    bit  steady;

    sent     = 0;
    big_done = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        wait_idle();
        write_reg(script[i].sel, script[i].value);
      end else begin
        offer_sample(SAMPLE_W'(script[i].value), pick_gap(), script[i].typed,
                     script[i].border_value);
      end
    end

    // Random phases: each one sets both registers and sends whole rows, often with a
    // partial row on top so that the next phase changes row_length in mid-row. A few
    // phases use lengths outside the legal range, and one uses the maximum length.
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (!big_done && sent >= RANDOM_ITEMS / 2) begin
        big_done = 1'b1;
        len_val  = LEN_MAX;
        n        = $urandom_range(12, 40);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          len_val = $urandom_range(0, LEN_MIN - 1);
        end else if (r < 9) begin
          len_val = (1 << POS_W) - 1;
        end else if (r < 12) begin
          len_val = $urandom_range(LEN_MAX + 1, (1 << POS_W) - 2);
        end else begin
          len_val = $urandom_range(LEN_MIN, 40);
        end
        eff_len = (len_val < LEN_MIN) ? LEN_MIN : len_val;
        if (len_val > LEN_MAX) begin
          n = $urandom_range(12, 40);
        end else begin
          n = eff_len * $urandom_range(1, 4);
          if ($urandom_range(0, 2) == 0) begin
            n += $urandom_range(1, eff_len - 1);
          end
        end
      end
      sent += n;
      write_reg(tbfa_pkg::REG_ROW_LENGTH, len_val);
      write_reg(tbfa_pkg::REG_KEEP_PHASE, $urandom_range(0, 1));
      steady = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        offer_sample(random_sample(), steady ? 0 : pick_gap(), 1'b0, 0);
      end
    end

    // Drain, then leave room for any stray result to show up.
    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && bands_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
